[src/cbs_pkg.sv]
// Shared widths, types and helpers for the 3x3 Cramer basis solver.
package cbs_pkg;

	// component format
	localparam int CW = 32;
	localparam int FB = 16;
	localparam int MIN_DET_W = 31;

	// internal widths
	localparam int PW = 2 * CW;
	localparam int MW = 2 * CW + 1;
	localparam int TW = 3 * CW + 1;
	localparam int DW = 3 * CW + 3;
	localparam int XW = DW + CW + FB + 2;

	// pipeline depths
	localparam int TRI_LAT = 5;
	localparam int DIV_LAT = CW + 1;
	localparam int LAT = TRI_LAT + 1 + DIV_LAT;

	// configuration port
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_MIN_DET = 1'b0;
	localparam logic [MIN_DET_W-1:0] MIN_DET_RST = MIN_DET_W'(1);

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [DW-1:0] det_t;
	typedef logic [XW-1:0] wide_t;

	localparam comp_t SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam comp_t SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	// per-item flags riding with each division
	typedef struct packed {
		logic neg;
		logic kill;
	} div_ctl_t;

	// magnitude of a determinant
	function automatic logic [DW-1:0] det_abs(input det_t d);
		logic [DW-1:0] u;
		u = d;
		return d[DW-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

[src/cbs_triple.sv]
// Pipelined triple product p . (q x r) at full precision, five register stages.
module cbs_triple (
	input  logic           clk,
	input  cbs_pkg::comp_t p [3],
	input  cbs_pkg::comp_t q [3],
	input  cbs_pkg::comp_t r [3],
	output cbs_pkg::det_t  res
);
	import cbs_pkg::*;

	logic signed [PW-1:0] pa_s1 [3];
	logic signed [PW-1:0] pb_s1 [3];
	comp_t p_s1 [3];
	logic signed [MW-1:0] mnr_s2 [3];
	comp_t p_s2 [3];
	logic signed [MW-1:0] plo_s3 [3];
	logic signed [MW-1:0] phi_s3 [3];
	logic signed [TW-1:0] term_s4 [3];
	det_t res_s5;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J1 = (i + 1) % 3;
		localparam int J2 = (i + 2) % 3;

		// cross product partial products
		always_ff @(posedge clk) begin
			pa_s1[i] <= q[J1] * r[J2];
			pb_s1[i] <= r[J1] * q[J2];
			p_s1[i] <= p[i];
		end

		// minors
		always_ff @(posedge clk) begin
			mnr_s2[i] <= MW'(pa_s1[i]) - MW'(pb_s1[i]);
			p_s2[i] <= p_s1[i];
		end

		// p times minor, split in a low and a high half
		always_ff @(posedge clk) begin
			plo_s3[i] <= p_s2[i] * $signed({1'b0, mnr_s2[i][CW-1:0]});
			phi_s3[i] <= p_s2[i] * $signed(mnr_s2[i][MW-1:CW]);
		end

		// recombine halves
		always_ff @(posedge clk) begin
			term_s4[i] <= (TW'(phi_s3[i]) <<< CW) + TW'(plo_s3[i]);
		end
	end

	// dot product sum
	always_ff @(posedge clk) begin
		res_s5 <= DW'(term_s4[0]) + DW'(term_s4[1]) + DW'(term_s4[2]);
	end

	assign res = res_s5;

endmodule

[src/cbs_div.sv]
// Pipelined restoring divider with rounding, saturation and sign, one quotient bit a stage.
module cbs_div (
	input  logic              clk,
	input  cbs_pkg::wide_t    num,
	input  cbs_pkg::wide_t    den,
	input  cbs_pkg::div_ctl_t ctl,
	output cbs_pkg::comp_t    coef,
	output cbs_pkg::div_ctl_t res_ctl
);
	import cbs_pkg::*;

	wide_t rem_q [CW];
	wide_t den_q [CW];
	logic [CW-2:0] quo_q [CW];
	logic ovf_q [CW];
	div_ctl_t ctl_q [CW];
	comp_t coef_q;
	div_ctl_t octl_q;
	logic [CW-1:0] qx;

	// overflow check: quotient at or above 2^(CW-1) saturates
	always_ff @(posedge clk) begin
		rem_q[0] <= num;
		den_q[0] <= den;
		ovf_q[0] <= num >= (den << (CW - 1));
		quo_q[0] <= '0;
		ctl_q[0] <= ctl;
	end

	for (genvar i = 1; i < CW; i++) begin : g_stage
		localparam int K = CW - 1 - i;
		wide_t sh;
		logic fits;
		assign sh = den_q[i-1] << K;
		assign fits = rem_q[i-1] >= sh;

		// one quotient bit
		always_ff @(posedge clk) begin
			rem_q[i] <= fits ? (rem_q[i-1] - sh) : rem_q[i-1];
			den_q[i] <= den_q[i-1];
			quo_q[i] <= quo_q[i-1] | ((CW-1)'(fits) << K);
			ovf_q[i] <= ovf_q[i-1];
			ctl_q[i] <= ctl_q[i-1];
		end
	end

	assign qx = {1'b0, quo_q[CW-1]};

	// sign, saturation and singular zeroing
	always_ff @(posedge clk) begin
		priority if (ctl_q[CW-1].kill) begin
			coef_q <= '0;
		end else if (ovf_q[CW-1]) begin
			coef_q <= ctl_q[CW-1].neg ? SAT_MIN : SAT_MAX;
		end else begin
			coef_q <= ctl_q[CW-1].neg ? $signed(-qx) : $signed(qx);
		end
		octl_q <= ctl_q[CW-1];
	end

	assign coef = coef_q;
	assign res_ctl = octl_q;

endmodule

[src/cramer_basis_solve_3x3.sv]
// Top level: 3x3 Cramer's-rule basis solver with APB threshold register.
//
// Usage: present target and basis vectors with start high; an item is taken
// at any edge where start is high and busy is low. busy is held low, so a new
// item may enter in every cycle: throughput is one item per clock.
// The pipeline has five stages of multiply and add for the four triple
// products, one stage for the singular test and the divider operands, then
// a divider of one quotient bit per stage plus an overflow stage and an
// output stage.
// Each result is shown for one cycle with done high; the receiver cannot
// stall, so results are never held back.
// solved is low on a singular basis, and the coefficients are then zero.
// min_det sits at byte address 0 and is written through the APB port; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Reset clears the item pipeline and sets min_det to 1.
module cramer_basis_solve_3x3 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cbs_pkg::comp_t               target_x,
	input  cbs_pkg::comp_t               target_y,
	input  cbs_pkg::comp_t               target_z,
	input  cbs_pkg::comp_t               basis_a_x,
	input  cbs_pkg::comp_t               basis_a_y,
	input  cbs_pkg::comp_t               basis_a_z,
	input  cbs_pkg::comp_t               basis_b_x,
	input  cbs_pkg::comp_t               basis_b_y,
	input  cbs_pkg::comp_t               basis_b_z,
	input  cbs_pkg::comp_t               basis_c_x,
	input  cbs_pkg::comp_t               basis_c_y,
	input  cbs_pkg::comp_t               basis_c_z,
	output logic                         done,
	output cbs_pkg::comp_t               coef_a,
	output cbs_pkg::comp_t               coef_b,
	output cbs_pkg::comp_t               coef_c,
	output logic                         solved,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cbs_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cbs_pkg::*;

	comp_t vx [3];
	comp_t va [3];
	comp_t vb [3];
	comp_t vc [3];
	det_t det, da, db, dc;
	logic [MIN_DET_W-1:0] min_det_q;
	logic vld_q [LAT];
	logic [DW-1:0] ad;
	logic sing;
	wide_t den_s6;
	wide_t num_s6 [3];
	div_ctl_t ctl_s6 [3];
	det_t nums [3];
	comp_t coefs [3];
	div_ctl_t octl [3];

	assign vx = '{target_x, target_y, target_z};
	assign va = '{basis_a_x, basis_a_y, basis_a_z};
	assign vb = '{basis_b_x, basis_b_y, basis_b_z};
	assign vc = '{basis_c_x, basis_c_y, basis_c_z};

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MIN_DET_RST;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_MIN_DET) begin
			min_det_q <= pwdata[MIN_DET_W-1:0];
		end
	end
	assign prdata = (paddr[ADDR_W-1:2] == REG_MIN_DET) ? 32'(min_det_q) : '0;

	// determinant and the three substituted determinants
	cbs_triple u_det (.clk(clk), .p(va), .q(vb), .r(vc), .res(det));
	cbs_triple u_da  (.clk(clk), .p(vx), .q(vb), .r(vc), .res(da));
	cbs_triple u_db  (.clk(clk), .p(va), .q(vx), .r(vc), .res(db));
	cbs_triple u_dc  (.clk(clk), .p(va), .q(vb), .r(vx), .res(dc));

	// singular test and divider operands
	assign ad = det_abs(det);
	assign sing = (det == '0) || (XW'(ad) < (XW'(min_det_q) << (2 * FB)));
	assign nums = '{da, db, dc};

	always_ff @(posedge clk) begin
		den_s6 <= XW'(ad) << 1;
	end

	for (genvar i = 0; i < 3; i++) begin : g_coef
		always_ff @(posedge clk) begin
			num_s6[i] <= (XW'(det_abs(nums[i])) << (FB + 1)) + XW'(ad);
			ctl_s6[i].neg <= nums[i][DW-1] ^ det[DW-1];
			ctl_s6[i].kill <= sing;
		end

		cbs_div u_div (
			.clk(clk), .num(num_s6[i]), .den(den_s6), .ctl(ctl_s6[i]),
			.coef(coefs[i]), .res_ctl(octl[i])
		);
	end

	// item valid pipeline
	assign busy = 1'b0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	assign done = vld_q[LAT-1];
	assign coef_a = coefs[0];
	assign coef_b = coefs[1];
	assign coef_c = coefs[2];
	assign solved = done && !octl[0].kill;

	// checks
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[0], LAT - 1))
		else $error("result without matching item");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !solved |-> coef_a == '0 && coef_b == '0 && coef_c == '0)
		else $error("singular result with nonzero coefficient");
	a_kill_agree: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> octl[0].kill == octl[1].kill && octl[1].kill == octl[2].kill)
		else $error("divider lanes out of step");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the 3x3 Cramer basis solver.
module testbench;
	import cbs_pkg::*;

	typedef logic signed [127:0] big_t;

	typedef struct {
		comp_t v[12];
	} problem_t;

	typedef struct {
		comp_t ca;
		comp_t cb;
		comp_t cc;
		logic  ok;
	} solution_t;

	// byte addresses on the register port
	localparam logic [ADDR_W-1:0] ADDR_MIN_DET = {REG_MIN_DET, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNUSED  = {1'b1, 2'b00};
	localparam int DRAIN = LAT + 8;
	localparam comp_t ONE_Q = 32'sd65536;

	// scoreboard: solves each accepted problem and checks the block's answers
	class solution_board;
		solution_t pending[$];
		logic [30:0] min_det;
		int errors;

		function new();
			min_det = 31'd1;
			errors = 0;
		endfunction

		function big_t triple3(big_t p[3], big_t q[3], big_t r[3]);
			big_t m0, m1, m2;
			m0 = q[1] * r[2] - r[1] * q[2];
			m1 = q[2] * r[0] - r[2] * q[0];
			m2 = q[0] * r[1] - r[0] * q[1];
			return p[0] * m0 + p[1] * m1 + p[2] * m2;
		endfunction

		// round to nearest, ties away from zero, then saturate
		function comp_t ratio(big_t num, big_t den);
			logic [159:0] an, ad, q, lim;
			logic neg;
			neg = num[127] ^ den[127];
			an = num[127] ? -num : num;
			ad = den[127] ? -den : den;
			q = ((an << (FB + 1)) + ad) / (ad << 1);
			lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
			if (q > lim)
				return neg ? SAT_MIN : SAT_MAX;
			return neg ? comp_t'(-q[31:0]) : comp_t'(q[31:0]);
		endfunction

		function void note_problem(problem_t p);
			big_t x[3], a[3], b[3], c[3];
			big_t det, mag, thr;
			solution_t s;
			for (int i = 0; i < 3; i++) begin
				x[i] = big_t'(p.v[i]);
				a[i] = big_t'(p.v[3 + i]);
				b[i] = big_t'(p.v[6 + i]);
				c[i] = big_t'(p.v[9 + i]);
			end
			det = triple3(a, b, c);
			mag = det < 0 ? -det : det;
			thr = big_t'({min_det, 32'd0});
			if (det == 0 || mag < thr) begin
				s = '{ca: '0, cb: '0, cc: '0, ok: 1'b0};
			end else begin
				s.ca = ratio(triple3(x, b, c), det);
				s.cb = ratio(triple3(a, x, c), det);
				s.cc = ratio(triple3(a, b, x), det);
				s.ok = 1'b1;
			end
			pending.push_back(s);
		endfunction

		function void check_solution(comp_t ca, comp_t cb, comp_t cc, logic ok);
			solution_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: coef_a=%0d solved=%0b", ca, ok);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ca !== e.ca) begin
				$error("coef_a expected %0d got %0d", e.ca, ca);
				errors++;
			end
			if (cb !== e.cb) begin
				$error("coef_b expected %0d got %0d", e.cb, cb);
				errors++;
			end
			if (cc !== e.cc) begin
				$error("coef_c expected %0d got %0d", e.cc, cc);
				errors++;
			end
			if (ok !== e.ok) begin
				$error("solved expected %0b got %0b", e.ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, solved, pready;
	comp_t in_v[12];
	comp_t coef_a, coef_b, coef_c;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic idle_on = 1'b1;
	solution_board board;

	initial foreach (in_v[i]) in_v[i] = '0;

	always #4 clk = ~clk;

	cramer_basis_solve_3x3 uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.target_x(in_v[0]), .target_y(in_v[1]), .target_z(in_v[2]),
		.basis_a_x(in_v[3]), .basis_a_y(in_v[4]), .basis_a_z(in_v[5]),
		.basis_b_x(in_v[6]), .basis_b_y(in_v[7]), .basis_b_z(in_v[8]),
		.basis_c_x(in_v[9]), .basis_c_y(in_v[10]), .basis_c_z(in_v[11]),
		.done(done), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.solved(solved), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_solution(coef_a, coef_b, coef_c, solved);
	end

	// present one problem and hold it until taken
	task automatic send_problem(input problem_t p);
		if (idle_on && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		foreach (in_v[i]) in_v[i] <= p.v[i];
		do @(posedge clk); while (busy);
		board.note_problem(p);
	endtask

	// let everything in flight come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MIN_DET)
			board.min_det = data[30:0];
	endtask

	function automatic comp_t pick_comp(input int mode);
		case (mode)
			0: return comp_t'($urandom);
			1: return comp_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: begin
				case ($urandom_range(0, 5))
					0: return SAT_MIN;
					1: return SAT_MAX;
					2: return '0;
					3: return -1;
					4: return ONE_Q;
					default: return comp_t'($urandom_range(0, 255));
				endcase
			end
		endcase
	endfunction

	function automatic problem_t random_problem();
		problem_t p;
		int mode;
		mode = $urandom_range(0, 9);
		foreach (p.v[i])
			p.v[i] = pick_comp(mode < 3 ? 0 : (mode < 8 ? 1 : 2));
		// dependent basis: C = A + B, or a repeated vector
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 3; i++) begin
				p.v[3 + i] = pick_comp(1);
				p.v[6 + i] = pick_comp(1);
				p.v[9 + i] = $urandom_range(0, 1) ? p.v[3 + i] + p.v[6 + i] : p.v[3 + i];
			end
		end
		return p;
	endfunction

	function automatic problem_t diag_problem(input comp_t d, input comp_t tx);
		problem_t p;
		foreach (p.v[i]) p.v[i] = '0;
		p.v[0] = tx;
		p.v[1] = -tx;
		p.v[2] = ONE_Q;
		p.v[3] = d;
		p.v[7] = d;
		p.v[11] = d;
		return p;
	endfunction

	task automatic random_phase(input int n);
		for (int k = 0; k < n; k++) begin
			idle_on = !(k >= n / 3 && k < n / 2);
			send_problem(random_problem());
		end
		idle_on = 1'b1;
	endtask

	// main sequence
	initial begin
		problem_t p;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases with the reset threshold
		foreach (p.v[i]) p.v[i] = '0;
		send_problem(p);
		foreach (p.v[i]) p.v[i] = SAT_MIN;
		send_problem(p);
		foreach (p.v[i]) p.v[i] = SAT_MAX;
		send_problem(p);
		send_problem(diag_problem(ONE_Q, comp_t'(32'h1234_5678)));
		send_problem(diag_problem(-ONE_Q, SAT_MIN));
		send_problem(diag_problem(comp_t'(1 << 8), SAT_MAX));
		send_problem(diag_problem(comp_t'(1 << 8), SAT_MIN));

		// threshold zero: tiny determinants, rounding ties
		write_reg(ADDR_MIN_DET, 32'd0);
		send_problem(diag_problem(comp_t'(2), comp_t'(1)));
		send_problem(diag_problem(comp_t'(1 << 17), comp_t'(1)));
		send_problem(diag_problem(comp_t'(1 << 17), comp_t'(-1)));
		send_problem(diag_problem(comp_t'(1 << 17), comp_t'(3)));
		send_problem(diag_problem(comp_t'(1), SAT_MAX));
		send_problem(diag_problem(comp_t'(-1), SAT_MAX));
		foreach (p.v[i]) p.v[i] = '0;
		p.v[0] = ONE_Q;
		send_problem(p);
		random_phase(400);

		// top threshold, bit 31 dropped
		write_reg(ADDR_MIN_DET, 32'hFFFF_FFFF);
		send_problem(diag_problem(SAT_MIN, ONE_Q));
		send_problem(diag_problem(comp_t'(1 << 21), ONE_Q));
		random_phase(300);

		// unused address leaves the threshold alone
		write_reg(ADDR_UNUSED, 32'd5);
		random_phase(100);

		write_reg(ADDR_MIN_DET, 32'd1);
		random_phase(400);
		write_reg(ADDR_MIN_DET, 32'd16);
		random_phase(300);
		write_reg(ADDR_MIN_DET, $urandom_range(0, 1 << 16));
		random_phase(300);

		drain();
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
src/cbs_pkg.sv
src/cbs_triple.sv
src/cbs_div.sv
src/cramer_basis_solve_3x3.sv
tb/testbench.sv
